// ===== design/imm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package imm_pkg;

    localparam int DATA_W          = 32;
    localparam int DIM_W           = 4;
    localparam int CFG_W           = 5;
    localparam int CFG_IDX_W       = 2;
    localparam int MAX_DIM_DEFAULT = 16;

    // Operation codes of an input item.
    localparam logic [1:0] FUNC_LOAD_A  = 2'd0;
    localparam logic [1:0] FUNC_LOAD_B  = 2'd1;
    localparam logic [1:0] FUNC_COMPUTE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B_COLS    = 2'd2;

    localparam logic [CFG_W-1:0] DIM_RESET = 5'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } state_t;

    // One multiply-accumulate step handed to the datapath.
    typedef struct packed {
        logic issue;
        logic first;
        logic last;
    } mac_ctl_t;

    // Store write strobes.
    typedef struct packed {
        logic en_a;
        logic en_b;
    } mem_wr_t;

    // Clamp a dimension register into 1 .. cap.
    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W-1:0] cap);
        logic [CFG_W-1:0] r;
        if (v == '0) begin
            r = 5'd1;
        end else if (v > cap) begin
            r = cap;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/imm_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module imm_datapath #(
    parameter int MAX_DIM = imm_pkg::MAX_DIM_DEFAULT
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire imm_pkg::mem_wr_t                      wr,
    input  wire logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    wr_addr,
    input  wire logic [imm_pkg::DATA_W-1:0]            wr_data,
    input  wire imm_pkg::mac_ctl_t                     ctl,
    input  wire logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    rd_addr_a,
    input  wire logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    rd_addr_b,
    output logic                                       sum_valid,
    output logic [imm_pkg::DATA_W-1:0]                 sum
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;

    logic [imm_pkg::DATA_W-1:0] a_mem [DEPTH];
    logic [imm_pkg::DATA_W-1:0] b_mem [DEPTH];

    logic [imm_pkg::DATA_W-1:0] a_rd_reg, b_rd_reg;
    logic [imm_pkg::DATA_W-1:0] prod_reg;
    logic [imm_pkg::DATA_W-1:0] acc_reg;
    logic [imm_pkg::DATA_W-1:0] acc_next;
    logic                       done_reg;
    imm_pkg::mac_ctl_t          s1_ctl_reg, s2_ctl_reg;

    always_ff @(posedge aclk) begin
        if (wr.en_a) begin
            a_mem[wr_addr] <= wr_data;
        end
        if (wr.en_b) begin
            b_mem[wr_addr] <= wr_data;
        end
        a_rd_reg <= a_mem[rd_addr_a];
        b_rd_reg <= b_mem[rd_addr_b];
    end

    // Low half of the product is the same for signed and unsigned operands.
    always_ff @(posedge aclk) begin
        prod_reg <= imm_pkg::DATA_W'(a_rd_reg * b_rd_reg);
    end

    always_comb begin
        if (s2_ctl_reg.first) begin
            acc_next = prod_reg;
        end else begin
            acc_next = acc_reg + prod_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_ctl_reg.issue) begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            done_reg   <= 1'b0;
        end else begin
            s1_ctl_reg <= ctl;
            s2_ctl_reg <= s1_ctl_reg;
            done_reg   <= s2_ctl_reg.issue & s2_ctl_reg.last;
        end
    end

    assign sum_valid = done_reg;
    assign sum       = acc_reg;

endmodule

`default_nettype wire

// ===== design/integer_matrix_multiply_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake           Payload
// s_        s_valid / s_ready   s_func, s_row, s_col, s_value
// m_        m_valid / m_ready   m_product, m_out_row, m_out_col, m_last
// cfg_      cfg_we (no wait)    cfg_index, cfg_wdata
//
// A load item writes the A or B store in the accept cycle.
// A compute item of a valid row runs its b_cols columns one after another:
// one shared 32x32 multiplier and accumulator walk the inner dimension, one
// store read a cycle while issue is not held, behind a read stage and a multiply stage.
// s_ready is high only when the sequencer is idle; m_ready low holds a column
// in the output register and delays the next column's start.
// aresetn is synchronous; the stores are not cleared and hold junk until written.
module integer_matrix_multiply_unit #(
    parameter int MAX_DIM = imm_pkg::MAX_DIM_DEFAULT
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // input items
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [1:0]                         s_func,
    input  wire logic [imm_pkg::DIM_W-1:0]          s_row,
    input  wire logic [imm_pkg::DIM_W-1:0]          s_col,
    input  wire logic signed [imm_pkg::DATA_W-1:0]  s_value,
    // result items
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [imm_pkg::DATA_W-1:0]       m_product,
    output logic [imm_pkg::DIM_W-1:0]               m_out_row,
    output logic [imm_pkg::DIM_W-1:0]               m_out_col,
    output logic                                    m_last,
    // configuration
    input  wire logic                               cfg_we,
    input  wire logic [imm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [imm_pkg::CFG_W-1:0]          cfg_wdata
);

    localparam int ADDR_W  = $clog2(MAX_DIM * MAX_DIM);
    localparam int DIM_CAP = (MAX_DIM < 16) ? MAX_DIM : 16;
    localparam logic [imm_pkg::CFG_W-1:0] CAP = imm_pkg::CFG_W'(DIM_CAP);

    // Configuration registers
    logic [imm_pkg::CFG_W-1:0] a_rows_reg, inner_len_reg, b_cols_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_rows_reg    <= imm_pkg::DIM_RESET;
            inner_len_reg <= imm_pkg::DIM_RESET;
            b_cols_reg    <= imm_pkg::DIM_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                imm_pkg::CFG_A_ROWS:    a_rows_reg    <= cfg_wdata;
                imm_pkg::CFG_INNER_LEN: inner_len_reg <= cfg_wdata;
                imm_pkg::CFG_B_COLS:    b_cols_reg    <= cfg_wdata;
                default: ;  // index past the register list: drop
            endcase
        end
    end

    // Sequencer state
    imm_pkg::state_t            state_reg, state_next;
    logic [imm_pkg::DIM_W-1:0]  row_reg, j_reg, x_reg;
    logic [imm_pkg::CFG_W-1:0]  inner_eff_reg, cols_eff_reg;

    logic                       s_accept;
    logic                       is_load_a, is_load_b, is_compute;
    logic                       load_in_range, compute_ok;
    logic [imm_pkg::CFG_W-1:0]  rows_eff;
    logic                       out_free;
    logic                       x_last, j_last;
    logic                       hold_issue;

    imm_pkg::mac_ctl_t          ctl;
    imm_pkg::mem_wr_t           wr;
    logic [ADDR_W-1:0]          wr_addr, rd_addr_a, rd_addr_b;
    logic                       sum_valid;
    logic [imm_pkg::DATA_W-1:0] sum;

    assign s_accept      = s_valid & s_ready;
    assign is_load_a     = (s_func == imm_pkg::FUNC_LOAD_A);
    assign is_load_b     = (s_func == imm_pkg::FUNC_LOAD_B);
    assign is_compute    = (s_func == imm_pkg::FUNC_COMPUTE);
    assign load_in_range = (int'(s_row) < MAX_DIM) && (int'(s_col) < MAX_DIM);
    assign rows_eff      = imm_pkg::clamp_dim(a_rows_reg, CAP);
    assign compute_ok    = is_compute && ({1'b0, s_row} < rows_eff);

    // A column may start once the output register is empty or emptying now.
    assign out_free   = !m_valid || m_ready;
    assign hold_issue = (x_reg == '0) && !out_free;
    assign x_last     = ({1'b0, x_reg} == inner_eff_reg - 1'b1);
    assign j_last     = ({1'b0, j_reg} == cols_eff_reg - 1'b1);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            imm_pkg::ST_IDLE: begin
                if (s_accept && compute_ok) begin
                    state_next = imm_pkg::ST_ISSUE;
                end
            end
            imm_pkg::ST_ISSUE: begin
                if (!hold_issue && x_last) begin
                    state_next = imm_pkg::ST_DRAIN;
                end
            end
            imm_pkg::ST_DRAIN: begin
                if (sum_valid) begin
                    state_next = j_last ? imm_pkg::ST_IDLE : imm_pkg::ST_ISSUE;
                end
            end
            default: state_next = imm_pkg::ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        s_ready   = 1'b0;
        ctl       = '0;
        wr        = '0;
        unique case (state_reg)
            imm_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                wr.en_a  = s_accept && is_load_a && load_in_range;
                wr.en_b  = s_accept && is_load_b && load_in_range;
            end
            imm_pkg::ST_ISSUE: begin
                ctl.issue = !hold_issue;
                ctl.first = (x_reg == '0);
                ctl.last  = x_last;
            end
            imm_pkg::ST_DRAIN: ;
            default: ;
        endcase
    end

    // Store addresses: row * MAX_DIM + col
    assign wr_addr   = ADDR_W'(s_row) * ADDR_W'(MAX_DIM) + ADDR_W'(s_col);
    assign rd_addr_a = ADDR_W'(row_reg) * ADDR_W'(MAX_DIM) + ADDR_W'(x_reg);
    assign rd_addr_b = ADDR_W'(x_reg) * ADDR_W'(MAX_DIM) + ADDR_W'(j_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= imm_pkg::ST_IDLE;
            x_reg     <= '0;
            j_reg     <= '0;
        end else begin
            state_reg <= state_next;
            priority if (state_reg == imm_pkg::ST_IDLE && s_accept && compute_ok) begin
                x_reg <= '0;
                j_reg <= '0;
            end else if (ctl.issue) begin
                // advance the inner index; wrap after the last term of a column
                x_reg <= x_last ? '0 : x_reg + 1'b1;
            end else if (state_reg == imm_pkg::ST_DRAIN && sum_valid && !j_last) begin
                j_reg <= j_reg + 1'b1;
            end else begin
                // hold both indexes while stalled, waiting or idle
            end
        end
    end

    // Latch the row and the clamped dimensions for the whole compute item.
    always_ff @(posedge aclk) begin
        if (state_reg == imm_pkg::ST_IDLE && s_accept && compute_ok) begin
            row_reg       <= s_row;
            inner_eff_reg <= imm_pkg::clamp_dim(inner_len_reg, CAP);
            cols_eff_reg  <= imm_pkg::clamp_dim(b_cols_reg, CAP);
        end
    end

    imm_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr        (wr),
        .wr_addr   (wr_addr),
        .wr_data   (s_value),
        .ctl       (ctl),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .sum_valid (sum_valid),
        .sum       (sum)
    );

    // Output register: load a finished column, hold it until taken.
    logic                        m_valid_reg;
    logic [imm_pkg::DATA_W-1:0]  m_product_reg;
    logic [imm_pkg::DIM_W-1:0]   m_out_row_reg, m_out_col_reg;
    logic                        m_last_reg;
    logic                        col_done;

    assign col_done = (state_reg == imm_pkg::ST_DRAIN) && sum_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (col_done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (col_done) begin
            m_product_reg <= sum;
            m_out_row_reg <= row_reg;
            m_out_col_reg <= j_reg;
            m_last_reg    <= j_last;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_product = m_product_reg;
    assign m_out_row = m_out_row_reg;
    assign m_out_col = m_out_col_reg;
    assign m_last    = m_last_reg;

    // A finished sum only shows up while the sequencer waits for it.
    a_sum_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        sum_valid |-> state_reg == imm_pkg::ST_DRAIN)
        else $error("column sum arrived outside the drain state");

    // The output register is empty when a column lands in it.
    a_out_free_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        col_done |-> !m_valid_reg)
        else $error("column result would overwrite a pending item");

    // Once a column has started issuing, no earlier item is still pending.
    a_no_pending_mid_column: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == imm_pkg::ST_ISSUE && x_reg != '0) |-> !m_valid_reg)
        else $error("pending item while a column is in flight");

    // A delivered last item ends the compute item: the sequencer is idle after it.
    a_last_then_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (col_done && j_last) |=> state_reg == imm_pkg::ST_IDLE)
        else $error("sequencer kept running after the last column");

endmodule

`default_nettype wire
